>>> rtl/gray_square_morphology_filter_defines.svh
// Assertion macros shared by the checker of the morphology filter.
// Depends on nothing; included by the checker file.
`ifndef GRAY_SQUARE_MORPHOLOGY_FILTER_DEFINES_SVH
`define GRAY_SQUARE_MORPHOLOGY_FILTER_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define GSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define GSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/gsm_pkg.sv
// Package of the grayscale morphology filter: sizes, register indexes, types.
// Depends on nothing.
`default_nettype none
package gsm_pkg;
  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxRadius = 15;
  localparam int PixW = 8;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_WINDOW_RADIUS = 2'd2,
    REG_FILTER_MODE  = 2'd3
  } reg_idx_t;

  // Steps of one pixel through the block.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_COLUMN = 2'd1,
    ST_WINDOW = 2'd2
  } phase_t;

  function automatic logic [7:0] pick(input logic [7:0] a, input logic [7:0] b,
                                      input logic dil);
    if (dil) pick = (a > b) ? a : b;
    else     pick = (a < b) ? a : b;
  endfunction
endpackage
`default_nettype wire

>>> rtl/gsm_cell.sv
// One cell of the column chain and the balanced extreme tree of the filter.
// The tree depends on gsm_pkg; the cell depends on nothing.
`default_nettype none
module gsm_cell (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [7:0] din,
  output logic [7:0]      dout
);
  // Each cell holds the vertical extreme of one column and passes it on
  // to its neighbor whenever the chain shifts.
  always_ff @(posedge clk) begin
    if (en) dout <= din;
  end
endmodule

module gsm_tree #(
  parameter int N = 31
) (
  input  wire logic [N*8-1:0] din,
  input  wire logic           dil,
  output logic [7:0]          dout
);
  import gsm_pkg::*;
  localparam int TreeN = 1 << $clog2(N);
  logic [7:0] node [TreeN];
  // Pairwise reduction keeps the depth at log2 of the input count.
  always_comb begin
    for (int i = 0; i < N; i++) node[i] = din[i*8 +: 8];
    for (int i = N; i < TreeN; i++) node[i] = dil ? 8'd0 : 8'd255;
    for (int s = 1; s < TreeN; s = s * 2)
      for (int i = 0; i + s < TreeN; i = i + 2 * s)
        node[i] = pick(node[i], node[i + s], dil);
    dout = node[0];
  end
endmodule
`default_nettype wire

>>> rtl/gray_square_morphology_filter.sv
// Top level of the square-window grayscale morphology filter.
// Depends on gsm_pkg, gsm_cell and gsm_tree.
//
// Use: pixels enter in raster order on the in channel (in_valid/in_ready,
// pixel_value, frame_start) and leave on the out channel (out_valid/out_ready)
// as the min (erosion) or max (dilation) over a (2r+1)-square window with the
// column and row of the center pixel. Border pixels produce no transfer.
// The user must write registers over the APB port only while the block is
// idle; the block itself does not enforce this. Each pixel of the frame moves
// through the idle, column and window states: the accepting edge reads its
// column word from the column history memory, the column state writes the
// word back with the new pixel, forms the column extreme through a tree and
// shifts the chain of cells, and the window state forms the window extreme
// from the chain and loads the output register. out_valid rises and in_ready
// returns as the window state ends. Pixels past the frame end move counters.
// Reset clears the position counters, the step state and the registers; the
// line store is not cleared, since no result uses an unwritten entry.
// When the receiver stalls, the result register holds, one more pixel is
// accepted and waits at its window step until the result register is free.
`default_nettype none
module gray_square_morphology_filter #(
  parameter int MAX_WIDTH  = gsm_pkg::DefMaxWidth,
  parameter int MAX_RADIUS = gsm_pkg::DefMaxRadius
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pixel_value,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       result_value,
  output logic [11:0]      out_col,
  output logic [15:0]      out_row,
  output logic             frame_done
);
  import gsm_pkg::*;
  localparam int Ring = 2 * MAX_RADIUS + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(Ring);

  logic [12:0] line_width;
  logic [15:0] frame_height;
  logic [3:0]  window_radius;
  logic        filter_mode;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 13'd4096; frame_height <= 16'd4096;
      window_radius <= 4'd15; filter_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LINE_WIDTH:    line_width <= pwdata[12:0];
        REG_FRAME_HEIGHT:  frame_height <= pwdata[15:0];
        REG_WINDOW_RADIUS: window_radius <= pwdata[3:0];
        REG_FILTER_MODE:   filter_mode <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_LINE_WIDTH:    prdata = {19'd0, line_width};
      REG_FRAME_HEIGHT:  prdata = {16'd0, frame_height};
      REG_WINDOW_RADIUS: prdata = {28'd0, window_radius};
      REG_FILTER_MODE:   prdata = {31'd0, filter_mode};
      default:           prdata = 32'd0;
    endcase
  end

  // Effective settings.
  logic [13:0] w;
  logic [4:0]  r;
  logic [5:0]  side;
  always_comb begin
    if (line_width == 13'd0) w = 14'd1;
    else if ({19'd0, line_width} > 32'(MAX_WIDTH)) w = 14'(MAX_WIDTH);
    else w = {1'b0, line_width};
    r = ({1'b0, window_radius} > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : {1'b0, window_radius};
    side = {r, 1'b0} + 6'd1;
  end

  // Position and ring row counters.
  logic [13:0] col_count;
  logic [16:0] row_count;
  logic [RW-1:0] ring_row;

  // Column history memory: one wide word of Ring pixels per column.
  logic [Ring*8-1:0] colmem [MAX_WIDTH];
  logic [Ring*8-1:0] rd_word;

  // Step control and the pixel held while it moves through the steps.
  phase_t      state;
  phase_t      state_next;
  logic        shift_en;
  logic        load_out;
  logic [7:0]  s_pix;
  logic [CW-1:0] s_col;
  logic [15:0] s_row;
  logic [RW-1:0] s_ring;
  logic        s_done;
  logic        s_emit;

  logic [13:0] c0;
  logic [16:0] r0;
  logic        active;
  logic [7:0]  ident;
  logic [Ring*8-1:0] new_word;
  logic [Ring*8-1:0] col_taps;
  logic [7:0]  vext;
  logic [7:0]  chain [Ring+1];
  logic [Ring*8-1:0] win_taps;
  logic [7:0]  hext;

  always_comb begin
    c0 = frame_start ? 14'd0 : col_count;
    r0 = frame_start ? 17'd0 : row_count;
    if (c0 >= w) c0 = 14'd0;
  end
  assign active = (r0 < {1'b0, frame_height});
  assign ident = filter_mode ? 8'd0 : 8'd255;

  // A pixel of the frame walks column then window; pixels past the frame end
  // only move the counters. A result waits at the window step while the
  // output register still holds an untaken result.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && active) state_next = ST_COLUMN;
      ST_COLUMN: state_next = ST_WINDOW;
      ST_WINDOW: if (!s_emit || !out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_COLUMN: shift_en = 1'b1;
      ST_WINDOW: load_out = s_emit && (!out_valid || out_ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) rd_word <= colmem[c0[CW-1:0]];
  end

  // Column word with the new pixel in its ring slot; slots beyond the
  // current window side are masked out of the column extreme.
  always_comb begin
    new_word = rd_word;
    new_word[s_ring*8 +: 8] = s_pix;
    for (int i = 0; i < Ring; i++)
      col_taps[i*8 +: 8] = (6'(i) < side) ? new_word[i*8 +: 8] : ident;
  end

  gsm_tree #(.N(Ring)) u_col_tree (.din(col_taps), .dil(filter_mode), .dout(vext));

  always_ff @(posedge clk) begin
    if (shift_en) colmem[s_col] <= new_word;
  end

  // Chain of cells holding the last Ring column extremes; after the shift,
  // cell g holds the column g places left of the current one.
  assign chain[0] = vext;
  for (genvar g = 0; g < Ring; g++) begin : g_cell
    gsm_cell u_cell (
      .clk(clk), .en(shift_en), .din(chain[g]), .dout(chain[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < Ring; i++)
      win_taps[i*8 +: 8] = (6'(i) <= {r, 1'b0}) ? chain[i+1] : ident;
  end

  gsm_tree #(.N(Ring)) u_win_tree (.din(win_taps), .dil(filter_mode), .dout(hext));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_valid <= 1'b0;
      col_count <= 14'd0; row_count <= 17'd0; ring_row <= '0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        if (active) begin
          if (c0 + 14'd1 >= w) begin
            col_count <= 14'd0;
            row_count <= r0 + 17'd1;
            ring_row <= (frame_start ? '0 : ring_row) + RW'(1) >= RW'(side)
                        ? '0 : (frame_start ? '0 : ring_row) + RW'(1);
          end else begin
            col_count <= c0 + 14'd1;
            row_count <= r0;
            if (frame_start) ring_row <= '0;
          end
        end else begin
          col_count <= c0;
          row_count <= r0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= hext;
      out_col <= 12'(s_col - CW'(r));
      out_row <= s_row - 16'(r);
      frame_done <= s_done;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_pix  <= pixel_value;
      s_col  <= c0[CW-1:0];
      s_row  <= r0[15:0];
      s_ring <= frame_start ? '0 : ring_row;
      s_emit <= (r0 >= 17'({r, 1'b0})) && (c0 >= 14'({r, 1'b0}));
      s_done <= (r0 + 17'd1 == {1'b0, frame_height}) && (c0 + 14'd1 == w);
    end
  end
endmodule
`default_nettype wire

>>> rtl/gsm_checker.sv
// Port-level checker of the morphology filter, bound to the top level.
// Depends on gray_square_morphology_filter_defines.svh.
`default_nettype none
`include "gray_square_morphology_filter_defines.svh"
module gsm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [7:0] result_value,
  input wire logic pready
);
  `GSM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_value), "result moved")
  `GSM_ASSERT_IMP(a_known, clk, rst, 1'b1, !$isunknown({in_ready, out_valid}), "handshake unknown")
  `GSM_ASSERT_IMP(a_value, clk, rst, out_valid, !$isunknown(result_value), "result unknown")
  `GSM_ASSERT_IMP(a_pready, clk, rst, 1'b1, pready, "pready low")
endmodule
bind gray_square_morphology_filter gsm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
  .pready(pready)
);
`default_nettype wire

>>> bench/tb_gray_square_morphology_filter.sv
// Self-checking testbench for the square-window grayscale morphology filter.
// Depends on gsm_pkg and the gray_square_morphology_filter RTL.
// Frames of random size, radius and mode are streamed and every result is
// compared with a built-in erosion/dilation predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_gray_square_morphology_filter;
  import gsm_pkg::*;

  // One expected window result.
  typedef struct {
    logic [7:0]  value;
    logic [11:0] col;
    logic [15:0] row;
    logic        done;
  } win_result_t;

  // Predictor of the filter with its own row ring, position and registers.
  class window_scoreboard;
    logic [7:0]  ring [31][4096];
    int          col_pos;
    int          row_pos;
    int          width_reg;
    int          height_reg;
    int          radius_reg;
    logic        dilate;
    win_result_t pending[$];
    int          errors;

    function new();
      col_pos = 0;
      row_pos = 0;
      width_reg = 4096;
      height_reg = 4096;
      radius_reg = 15;
      dilate = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, int value);
      case (idx)
        REG_LINE_WIDTH: width_reg = value & 16'h1fff;
        REG_FRAME_HEIGHT: height_reg = value & 16'hffff;
        REG_WINDOW_RADIUS: radius_reg = value & 4'hf;
        default: dilate = value[0];
      endcase
    endfunction

    // Account for one accepted pixel and queue the window result it completes.
    function void note_pixel(logic [7:0] pix, logic start);
      int w;
      int side;
      logic [7:0] acc;
      logic [7:0] v;
      win_result_t res;
      w = (width_reg == 0) ? 1 : ((width_reg > 4096) ? 4096 : width_reg);
      side = 2 * radius_reg + 1;
      if (start) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (row_pos >= height_reg) return;
      if (col_pos >= w) col_pos = 0;
      ring[row_pos % side][col_pos] = pix;
      if (row_pos >= 2 * radius_reg && col_pos >= 2 * radius_reg) begin
        acc = dilate ? 8'd0 : 8'd255;
        for (int dy = 0; dy < side; dy++) begin
          for (int dx = 0; dx < side; dx++) begin
            v = ring[(row_pos - 2 * radius_reg + dy) % side][col_pos - 2 * radius_reg + dx];
            if (dilate ? (v > acc) : (v < acc)) acc = v;
          end
        end
        res.value = acc;
        res.col = 12'(col_pos - radius_reg);
        res.row = 16'(row_pos - radius_reg);
        res.done = (row_pos + 1 == height_reg) && (col_pos + 1 == w);
        pending.push_back(res);
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    endfunction

    function void check_result(logic [7:0] value, logic [11:0] col, logic [15:0] row,
                               logic done);
      win_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d col=%0d row=%0d", $time, value, col, row);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value) begin
        $display("%0t: result_value expected %0d actual %0d", $time, exp_res.value, value);
        errors++;
      end
      if (col !== exp_res.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, exp_res.col, col);
        errors++;
      end
      if (row !== exp_res.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, exp_res.row, row);
        errors++;
      end
      if (done !== exp_res.done) begin
        $display("%0t: frame_done expected %0d actual %0d", $time, exp_res.done, done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel_value;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  result_value;
  logic [11:0] out_col;
  logic [15:0] out_row;
  logic        frame_done;

  // Traffic controls of the sender and the receiver; quiet is shared by both.
  logic quiet;
  logic hold_go;
  logic hold_done;
  int   hold_left;
  int   pixels_sent;

  window_scoreboard sb = new();

  gray_square_morphology_filter u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_value(pixel_value), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .out_col(out_col), .out_row(out_row),
    .frame_done(frame_done)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Transfers are sampled at the edge, before any driver update of this step.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_pixel(pixel_value, frame_start);
      if (out_valid && out_ready) sb.check_result(result_value, out_col, out_row, frame_done);
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while quiet.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 17);
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic apb_write(reg_idx_t idx, int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Waits until every expected result has arrived, then lets the pipe settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int r, int m);
    drain();
    apb_write(REG_LINE_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
    apb_write(REG_WINDOW_RADIUS, r);
    apb_write(REG_FILTER_MODE, m);
  endtask

  // Offers one pixel and waits for its transfer. Valid drops only for idle gaps.
  task automatic send_pixel(logic [7:0] p, logic start);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= p;
    frame_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Streams npix pixels starting a frame; style picks the content.
  task automatic send_frame(int npix, int style);
    logic [7:0] p;
    for (int i = 0; i < npix; i++) begin
      case (style)
        1: p = 8'd0;
        2: p = 8'd255;
        3: p = (i % 2) ? 8'd255 : 8'd0;
        default: p = $urandom_range(255);
      endcase
      send_pixel(p, i == 0);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int w;
    int h;
    int r;
    int extra;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    pixel_value = '0;
    frame_start = 1'b0;
    quiet = 1'b0;
    hold_go = 1'b0;
    pixels_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: pixel extremes in both modes, a zero radius, a zero width
    // that acts as one, a zero height that ignores everything, and rows past
    // the frame end that must be dropped.
    configure(4, 4, 1, 0);
    send_frame(16, 3);
    configure(4, 3, 1, 1);
    send_frame(12, 2);
    send_frame(12, 1);
    configure(0, 3, 0, 1);
    send_frame(5, 0);
    configure(3, 0, 0, 0);
    send_frame(4, 0);
    // Width above the store size acts as the maximum.
    configure(8191, 1, 0, 0);
    send_frame(40, 0);
    // Largest radius on the smallest image that still yields one result.
    configure(31, 31, 15, 1);
    send_frame(961, 0);
    // Tallest frame: only a few rows are sent before the next frame restarts.
    configure(1, 65535, 0, 0);
    send_frame(6, 0);

    // Random frames: mostly complete, some cut short, some with trailing pixels.
    // The second frame runs under a long receiver hold-off, and a few frames
    // after it run with no idling on either side.
    for (int f = 0; pixels_sent < 1350; f++) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
      h = $urandom_range(8, 1);
      r = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(3);
      if (f == 1) begin
        w = 10;
        h = 6;
        r = 1;
      end
      configure(w, h, r, $urandom_range(1));
      quiet = (f >= 2 && f < 6);
      if (f == 1) hold_go = 1'b1;
      extra = ($urandom_range(9) == 0) ? $urandom_range(8, 1) : 0;
      if ($urandom_range(9) == 0)
        send_frame($urandom_range(w * h, 1), 0);
      send_frame(w * h + extra, ($urandom_range(15) == 0) ? $urandom_range(3) : 0);
      if (f == 1) begin
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    quiet = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
